>>> rtl/hht_pkg.sv
package hht_pkg;
  localparam int TABLE_DEPTH  = 1024;
  localparam int NEIGHBORHOOD = 32;
  localparam int PROBE_LIMIT  = 250;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CAP_W = IDX_W + 1;
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int ENT_W = 1 + KEY_W + VAL_W + IDX_W;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED      = 3'd0;
  localparam logic [2:0] ST_UPDATED       = 3'd1;
  localparam logic [2:0] ST_FOUND         = 3'd2;
  localparam logic [2:0] ST_REMOVED       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd4;
  localparam logic [2:0] ST_FULL          = 3'd5;
  localparam logic [2:0] ST_NO_FREE       = 3'd6;
  localparam logic [2:0] ST_DISPLACE_FAIL = 3'd7;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key_bytes;
    logic [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] value_out;
    logic [CAP_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [IDX_W-1:0] home;
  } ent_t;
endpackage

>>> rtl/hht_if.sv
interface hht_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/hht_ram.sv
module hht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/hht_hash.sv
// sdbm hash, one byte per cycle, then modulo by restoring division, one bit per cycle.
module hht_hash
  import hht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [CAP_W-1:0] cap,
  output logic             done,
  output logic [IDX_W-1:0] home
);
  typedef enum logic [1:0] {H_IDLE, H_HASH, H_MOD} hstate_t;
  hstate_t     st_r;
  logic [63:0] h_r, q_r;
  logic [CAP_W-1:0] rem_r;
  logic [6:0]  cnt_r;
  logic [KEY_W-1:0] k_r;
  logic [7:0]  b;
  logic [CAP_W:0] trial;

  assign b     = k_r[7:0];
  assign trial = {rem_r, q_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        H_IDLE: if (start) begin
          k_r <= key; h_r <= '0; cnt_r <= '0; st_r <= H_HASH;
        end
        H_HASH: begin
          if (b == 8'd0 || cnt_r == 7'd8) begin
            q_r <= h_r; rem_r <= '0; cnt_r <= '0; st_r <= H_MOD;
          end else begin
            h_r   <= {56'd0, b} + (h_r << 6) + (h_r << 16) - h_r;
            k_r   <= k_r >> 8;
            cnt_r <= cnt_r + 7'd1;
          end
        end
        H_MOD: begin
          q_r <= q_r << 1;
          if (trial >= {1'b0, cap}) rem_r <= CAP_W'(trial - {1'b0, cap});
          else rem_r <= trial[CAP_W-1:0];
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            st_r <= H_IDLE; done <= 1'b1;
          end
        end
        default: st_r <= H_IDLE;
      endcase
    end
  end
  assign home = rem_r[IDX_W-1:0];
endmodule

>>> rtl/hopscotch_hash_table.sv
// Sequence: hashing (a start step, one step per key byte and one more, 64 modulo steps,
//   a handoff), then a request and a wait state per slot read: up to 32 slots for look up
//   and remove, and for insert the neighbourhood, the free-slot probe (up to 250) and a
//   displacement sweep of up to 31 slots plus a move state per hop; a final check state closes each scan.
// Throughput: one transaction at a time; the slot RAM port sets the per-slot cost.
// Reset: synchronous, active low; a clearing pass then writes every slot invalid,
//   during which no transaction is accepted.
module hopscotch_hash_table
  import hht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hht_if.sink              in_ch,
  hht_if.source            out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FIND, S_FIND_W, S_PROBE, S_PROBE_W,
    S_DISP, S_DISP_W, S_MOVE, S_WRITE, S_OUT
  } state_t;

  state_t st_r;
  logic [CAP_W-1:0] cap_reg_r, cap_r, cnt_r;
  req_t   req_r;
  rsp_t   rsp_r;
  logic [IDX_W-1:0] home_r;
  logic [CAP_W:0]   idx_r, free_r, low_r;
  logic             ram_we;
  logic [IDX_W-1:0] waddr, raddr;
  ent_t             wdata, rdata;
  logic             hash_start, hash_done;
  logic [IDX_W-1:0] hash_home;
  logic [KEY_W-1:0] nkey;
  logic [CAP_W-1:0] eff_cap;
  logic             hit;
  logic [CAP_W:0]   home_x;

  // drop every byte after the first zero byte
  always_comb begin
    logic stop;
    stop = 1'b0;
    nkey = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_ch.data[VAL_W+8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) nkey[8*i +: 8] = in_ch.data[VAL_W+8*i +: 8];
    end
  end

  always_comb begin
    eff_cap = cap_reg_r;
    if (cap_reg_r == '0) eff_cap = CAP_W'(1);
    if (cap_reg_r > CAP_W'(TABLE_DEPTH)) eff_cap = CAP_W'(TABLE_DEPTH);
  end

  assign home_x = {1'b0, 1'b0, home_r};
  assign hit = rdata.vld && rdata.key == req_r.key_bytes;

  hht_hash u_hash (
    .clk, .rst_n, .start(hash_start), .key(req_r.key_bytes), .cap(cap_r),
    .done(hash_done), .home(hash_home)
  );

  hht_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk, .we(ram_we), .waddr, .wdata, .raddr, .rdata
  );

  logic     we_r;
  logic [IDX_W-1:0] wa_r;
  ent_t     wd_r, mv_r;
  assign ram_we = we_r;
  assign waddr  = wa_r;
  assign wdata  = wd_r;
  // present the slot under test so its entry is ready in the following wait state
  assign raddr  = (st_r == S_PROBE) ? free_r[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign hash_start = (st_r == S_HASH) && !hash_done && !we_r;

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      cap_reg_r <= CAP_W'(TABLE_DEPTH);
      cnt_r     <= '0;
      idx_r     <= '0;
      we_r      <= 1'b0;
    end else begin
      if (cfg_we) cap_reg_r <= cfg_wdata;
      we_r <= 1'b0;
      case (st_r)
        S_CLEAR: begin
          // sweep the slot RAM, one invalid entry per cycle
          we_r <= 1'b1; wa_r <= idx_r[IDX_W-1:0]; wd_r <= '0;
          idx_r <= idx_r + 1'b1;
          if (idx_r == (CAP_W+1)'(TABLE_DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          req_r <= '{action: in_ch.data[VAL_W+KEY_W +: 2], key_bytes: nkey,
                     value_in: in_ch.data[VAL_W-1:0]};
          cap_r <= eff_cap;
          st_r  <= S_HASH;
        end
        S_HASH: if (hash_done) begin
          home_r <= hash_home;
          idx_r  <= {2'b00, hash_home};
          rsp_r  <= '{status: (req_r.action == ACT_INSERT && cnt_r >= cap_r) ?
                              ST_FULL : ST_NOT_FOUND,
                      value_out: '0, occupancy: cnt_r};
          if (req_r.action == ACT_INSERT && cnt_r >= cap_r) begin
            st_r <= S_OUT;
          end else if (req_r.action == ACT_NONE) begin
            st_r <= S_OUT;
          end else begin
            st_r <= S_FIND;
          end
        end
        S_FIND: begin
          // search the neighbourhood, stopping at the end of the capacity
          if (idx_r >= home_x + (CAP_W+1)'(NEIGHBORHOOD) || idx_r >= {1'b0, cap_r}) begin
            if (req_r.action == ACT_INSERT) begin
              free_r <= home_x; st_r <= S_PROBE;
            end else st_r <= S_OUT;
          end else begin
            st_r <= S_FIND_W;
          end
        end
        S_FIND_W: begin
          if (hit) begin
            if (req_r.action == ACT_INSERT) begin
              we_r <= 1'b1; wa_r <= idx_r[IDX_W-1:0];
              wd_r <= '{vld: rdata.vld, key: rdata.key, val: req_r.value_in,
                        home: rdata.home};
              rsp_r.status <= ST_UPDATED;
            end else if (req_r.action == ACT_LOOKUP) begin
              rsp_r.status <= ST_FOUND; rsp_r.value_out <= rdata.val;
            end else begin
              we_r <= 1'b1; wa_r <= idx_r[IDX_W-1:0];
              wd_r <= '{vld: 1'b0, key: rdata.key, val: rdata.val, home: rdata.home};
              rsp_r.status <= ST_REMOVED; rsp_r.value_out <= rdata.val;
              if (cnt_r != '0) begin
                cnt_r <= cnt_r - 1'b1; rsp_r.occupancy <= cnt_r - 1'b1;
              end
            end
            st_r <= S_OUT;
          end else begin
            idx_r <= idx_r + 1'b1; st_r <= S_FIND;
          end
        end
        S_PROBE: begin
          if (free_r >= home_x + (CAP_W+1)'(PROBE_LIMIT) || free_r >= {1'b0, cap_r}) begin
            rsp_r.status <= ST_NO_FREE; st_r <= S_OUT;
          end else begin
            st_r <= S_PROBE_W;
          end
        end
        S_PROBE_W: begin
          if (rdata.vld) begin
            free_r <= free_r + 1'b1; st_r <= S_PROBE;
          end else if (free_r - home_x > (CAP_W+1)'(NEIGHBORHOOD - 1)) begin
            low_r <= free_r - (CAP_W+1)'(NEIGHBORHOOD - 1);
            idx_r <= free_r - (CAP_W+1)'(NEIGHBORHOOD - 1);
            st_r  <= S_DISP;
          end else st_r <= S_WRITE;
        end
        S_DISP: begin
          if (idx_r >= free_r) begin
            rsp_r.status <= ST_DISPLACE_FAIL; st_r <= S_OUT;
          end else begin
            st_r <= S_DISP_W;
          end
        end
        S_DISP_W: begin
          if (rdata.vld && {2'b00, rdata.home} >= low_r && {2'b00, rdata.home} <= free_r) begin
            // hop the candidate forward into the free slot
            we_r <= 1'b1; wa_r <= free_r[IDX_W-1:0]; wd_r <= rdata;
            mv_r <= rdata;
            st_r <= S_MOVE;
          end else begin
            idx_r <= idx_r + 1'b1; st_r <= S_DISP;
          end
        end
        S_MOVE: begin
          we_r <= 1'b1; wa_r <= idx_r[IDX_W-1:0];
          wd_r <= '{vld: 1'b0, key: mv_r.key, val: mv_r.val, home: mv_r.home};
          free_r <= idx_r;
          if (idx_r - home_x > (CAP_W+1)'(NEIGHBORHOOD - 1)) begin
            low_r <= idx_r - (CAP_W+1)'(NEIGHBORHOOD - 1);
            idx_r <= idx_r - (CAP_W+1)'(NEIGHBORHOOD - 1);
            st_r  <= S_DISP;
          end else st_r <= S_WRITE;
        end
        S_WRITE: begin
          we_r <= 1'b1; wa_r <= free_r[IDX_W-1:0];
          wd_r <= '{vld: 1'b1, key: req_r.key_bytes, val: req_r.value_in, home: home_r};
          cnt_r <= cnt_r + 1'b1;
          rsp_r.status <= ST_INSERTED; rsp_r.occupancy <= cnt_r + 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP_W'(TABLE_DEPTH))
    else $error("occupancy beyond depth");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted while busy");
`endif
endmodule

>>> bench/hht_score.sv
package hht_score;
  import hht_pkg::*;

  class table_scoreboard;
    bit [KEY_W-1:0] key_at [TABLE_DEPTH];
    bit [VAL_W-1:0] val_at [TABLE_DEPTH];
    int unsigned    home_at [TABLE_DEPTH];
    bit             used_at [TABLE_DEPTH];
    int unsigned    count;
    int unsigned    capacity;
    rsp_t           pending [$];
    int             errors;

    function new();
      count = 0;
      capacity = TABLE_DEPTH;
      errors = 0;
      foreach (used_at[i]) used_at[i] = 1'b0;
    endfunction

    function void set_capacity(bit [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned live_capacity();
      if (capacity == 0) return 1;
      if (capacity > TABLE_DEPTH) return TABLE_DEPTH;
      return capacity;
    endfunction

    function bit [KEY_W-1:0] trim_key(bit [KEY_W-1:0] k);
      bit [KEY_W-1:0] o;
      o = '0;
      for (int i = 0; i < 8; i++) begin
        if (k[8*i +: 8] == 8'd0) break;
        o[8*i +: 8] = k[8*i +: 8];
      end
      return o;
    endfunction

    function int unsigned sdbm_home(bit [KEY_W-1:0] k, int unsigned cap);
      bit [63:0] h;
      h = '0;
      for (int i = 0; i < 8; i++) begin
        if (k[8*i +: 8] == 8'd0) break;
        h = {56'd0, k[8*i +: 8]} + (h << 6) + (h << 16) - h;
      end
      return int'(h % 64'(cap));
    endfunction

    function int search(bit [KEY_W-1:0] k, int unsigned h, int unsigned cap);
      for (int unsigned i = h; i < h + NEIGHBORHOOD && i < cap; i++)
        if (used_at[i] && key_at[i] == k) return int'(i);
      return -1;
    endfunction

    function bit [2:0] insert(bit [KEY_W-1:0] k, bit [VAL_W-1:0] v,
                              int unsigned h, int unsigned cap);
      int hit;
      int unsigned spot, lim, low;
      bit moved;
      if (count >= cap) return ST_FULL;
      hit = search(k, h, cap);
      if (hit >= 0) begin
        val_at[hit] = v;
        return ST_UPDATED;
      end
      lim = h + PROBE_LIMIT;
      spot = h;
      while (spot < lim && spot < cap && used_at[spot]) spot++;
      if (spot >= lim || spot >= cap) return ST_NO_FREE;
      while (spot - h > NEIGHBORHOOD - 1) begin
        low = spot - (NEIGHBORHOOD - 1);
        moved = 1'b0;
        for (int unsigned c = low; c < spot; c++) begin
          if (used_at[c] && home_at[c] >= low && home_at[c] <= spot) begin
            used_at[spot] = 1'b1;
            key_at[spot] = key_at[c];
            val_at[spot] = val_at[c];
            home_at[spot] = home_at[c];
            used_at[c] = 1'b0;
            spot = c;
            moved = 1'b1;
            break;
          end
        end
        if (!moved) return ST_DISPLACE_FAIL;
      end
      used_at[spot] = 1'b1;
      key_at[spot] = k;
      val_at[spot] = v;
      home_at[spot] = h;
      count++;
      return ST_INSERTED;
    endfunction

    // Work out the response to an accepted request and queue it.
    function void note_request(req_t r);
      rsp_t e;
      bit [KEY_W-1:0] k;
      int unsigned cap, h;
      int hit;
      k = trim_key(r.key_bytes);
      cap = live_capacity();
      h = sdbm_home(k, cap);
      e.status = ST_NOT_FOUND;
      e.value_out = '0;
      if (r.action == ACT_INSERT) begin
        e.status = insert(k, r.value_in, h, cap);
      end else if (r.action == ACT_LOOKUP || r.action == ACT_REMOVE) begin
        hit = search(k, h, cap);
        if (hit >= 0) begin
          e.value_out = val_at[hit];
          if (r.action == ACT_LOOKUP) begin
            e.status = ST_FOUND;
          end else begin
            e.status = ST_REMOVED;
            used_at[hit] = 1'b0;
            if (count > 0) count--;
          end
        end
      end
      e.occupancy = CAP_W'(count);
      pending.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected response", 64'(got), 64'd0);
      end else begin
        e = pending.pop_front();
        if (got.status !== e.status) report("status", 64'(got.status), 64'(e.status));
        if (got.value_out !== e.value_out)
          report("value_out", 64'(got.value_out), 64'(e.value_out));
        if (got.occupancy !== e.occupancy)
          report("occupancy", 64'(got.occupancy), 64'(e.occupancy));
      end
    endtask
  endclass
endpackage

>>> bench/hopscotch_hash_table_test.sv
module hopscotch_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hht_pkg::*;
  import hht_score::*;

  localparam int REQ_W = $bits(req_t);
  localparam int RSP_W = $bits(rsp_t);
  localparam longint CYCLE_LIMIT = 50000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  hht_if #(.W(REQ_W)) in_ch ();
  hht_if #(.W(RSP_W)) out_ch ();

  hopscotch_hash_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  table_scoreboard board;
  // Idle percentage for either side; zero during the displacement phase.
  int idle_pct = 17;
  longint cycles = 0;
  bit [KEY_W-1:0] key_pool [16];

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Watchdog: abandon the run if it outgrows any plausible correct duration.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hopscotch_hash_table_test: done, errors");
      $finish;
    end
  end

  // Result side: stall at random, check every transaction taken.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_response(rsp_t'(out_ch.data));
    out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  // Offer one request, hold it until taken, and note it on acceptance.
  task send(logic [1:0] act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    req_t r;
    r.action = act;
    r.key_bytes = k;
    r.value_in = v;
    // Drop valid while idling; it stays high when the next request follows at once.
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(r);
  endtask

  // Wait for every response, then let the clock run on idle before returning.
  task drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_capacity(c);
    @(posedge clk);
  endtask

  function logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    // Short keys often, so zero terminators land at every byte position.
    if ($urandom_range(3) == 0) k[8*$urandom_range(7) +: 8] = 8'd0;
    return k;
  endfunction

  // Mostly pool keys so updates, hits and removes happen; a few fresh keys.
  task random_phase(int n);
    logic [1:0] act;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(19) == 0) ? ACT_NONE : 2'($urandom_range(2));
      k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : rand_key();
      send(act, k, $urandom);
    end
  endtask

  initial begin
    board = new();
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of keys and values, every action.
    send(ACT_LOOKUP, 64'd0, 32'd0);
    send(ACT_INSERT, 64'd0, 32'hFFFF_FFFF);
    send(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
    send(ACT_LOOKUP, 64'h5555_0000_0000_FFFF, 32'd7);
    send(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send(ACT_REMOVE, 64'h0000_0000_0000_0000, 32'd0);
    send(ACT_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
    send(ACT_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
    send(ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);

    // Capacity of zero acts as one; table fills at once.
    set_capacity('0);
    send(ACT_INSERT, 64'h0102, 32'd1);
    send(ACT_INSERT, 64'h0103, 32'd2);
    send(ACT_INSERT, 64'h0102, 32'd3);

    // Small capacity: probing hits the end of the table, no free slot.
    set_capacity(CAP_W'(3));
    for (int i = 1; i <= 6; i++) send(ACT_INSERT, 64'(i * 37), 32'(i));

    // Above the depth clamps to the depth.
    set_capacity({CAP_W{1'b1}});
    random_phase(150);

    // Small capacity with a crowded table drives displacement.
    set_capacity(CAP_W'(40));
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    idle_pct = 0;
    random_phase(250);
    idle_pct = 17;

    set_capacity(CAP_W'(300));
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    random_phase(200);

    set_capacity(CAP_W'(TABLE_DEPTH));
    random_phase(230);

    drain();
    if (board.errors == 0) begin
      $display("hopscotch_hash_table_test: done, clean");
    end else begin
      $display("hopscotch_hash_table_test: done, errors");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/hht_pkg.sv
rtl/hht_if.sv
rtl/hht_ram.sv
rtl/hht_hash.sv
rtl/hopscotch_hash_table.sv
bench/hht_score.sv
bench/hopscotch_hash_table_test.sv
